@@ sv/lwkz_pkg.sv @@
// Shared types and constants for the longest-window-with-k-zeros core.
// Used by lwkz_ctrl, lwkz_track and longest_window_k_zeros_core; no dependencies.
`default_nettype none

package lwkz_pkg;

  // Width of the configuration register that holds the zero limit.
  localparam int unsigned LimitW = 8;

  // Width of the best_length result field.
  localparam int unsigned BestW = 17;

  // Byte-padded widths of the stream data buses.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  // Per-beat control passed from the ring stage to the window stage.
  typedef struct packed {
    logic win;   // element lies within MAX_LEN and updates the window
    logic pop;   // oldest zero leaves the ring, window start jumps past it
    logic fwd;   // the popped zero is the one written by this beat
    logic last;  // beat closes the sequence
    logic ovf;   // sequence has gone beyond MAX_LEN elements
  } step_t;

endpackage

`default_nettype wire

@@ sv/lwkz_ring_ram.sv @@
// Zero-position ring storage: one write port, one read port, registered read data.
// Depends on nothing; instantiated by longest_window_k_zeros_core.
`default_nettype none

module lwkz_ring_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8,
  parameter int unsigned DataW = 17
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/lwkz_ctrl.sv @@
// Ring stage: head/tail pointers, zero count, position and overflow tracking.
// Issues the ring write and the read of the oldest zero. Uses lwkz_pkg.
`default_nettype none

module lwkz_ctrl #(
  parameter int unsigned MaxLen = 65536,
  parameter int unsigned MaxK   = 255,
  parameter int unsigned PosW   = 17,
  parameter int unsigned AddrW  = 8,
  parameter int unsigned CntW   = 9
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [lwkz_pkg::LimitW-1:0] max_zeros_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        bit_value_i,
  input  wire logic                        last_item_i,
  input  wire logic                        s1_ready_i,
  output logic                             s1_valid_o,
  output lwkz_pkg::step_t                  s1_step_o,
  output logic [PosW-1:0]                  s1_pos_o,
  output logic                             ram_we_o,
  output logic [AddrW-1:0]                 ram_waddr_o,
  output logic [PosW-1:0]                  ram_wdata_o,
  output logic                             ram_re_o,
  output logic [AddrW-1:0]                 ram_raddr_o
);

  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_inc, limit;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             ovf_q, ovf_d;
  logic             s1_valid_q, s1_valid_d;
  lwkz_pkg::step_t  step_q, step_d;
  logic [PosW-1:0]  spos_q;
  logic             accept, ovf_now, is_zero, wr, pop;

  // Effective limit saturates at MaxK.
  always_comb begin
    if (32'(max_zeros_i) > 32'(MaxK)) begin
      limit = CntW'(MaxK);
    end else begin
      limit = CntW'(max_zeros_i);
    end
  end

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Push a zero at the tail, then pop the oldest one if the count is over the limit.
  assign ovf_now = pos_q >= PosW'(MaxLen);
  assign is_zero = !bit_value_i && !ovf_now;
  assign wr      = is_zero && (32'(cnt_q) < MaxK + 1);
  assign cnt_inc = cnt_q + CntW'(wr);
  assign pop     = is_zero && (cnt_inc > limit) && (cnt_inc != '0);

  assign ram_we_o    = accept && wr;
  assign ram_waddr_o = tail_q;
  assign ram_wdata_o = pos_q;
  assign ram_re_o    = accept && pop;
  assign ram_raddr_o = head_q;

  // Next state of the sequence registers.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    pos_d  = pos_q;
    ovf_d  = ovf_q;
    step_d = step_q;
    if (accept) begin
      step_d.win  = !ovf_now;
      step_d.pop  = pop;
      step_d.fwd  = pop && wr && (cnt_q == '0);
      step_d.last = last_item_i;
      step_d.ovf  = ovf_q || ovf_now;
      if (ovf_now) begin
        ovf_d = 1'b1;
      end else begin
        if (wr) begin
          tail_d = (tail_q == AddrW'(MaxK)) ? '0 : tail_q + AddrW'(1);
        end
        if (pop) begin
          head_d = (head_q == AddrW'(MaxK)) ? '0 : head_q + AddrW'(1);
        end
        cnt_d = pop ? cnt_inc - CntW'(1) : cnt_inc;
        pos_d = pos_q + PosW'(1);
      end
      if (last_item_i) begin
        head_d = '0;
        tail_d = '0;
        cnt_d  = '0;
        pos_d  = '0;
        ovf_d  = 1'b0;
      end
    end
  end

  assign s1_valid_d = accept ? 1'b1 : (s1_ready_i ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
      pos_q      <= '0;
      ovf_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      ovf_q      <= ovf_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Beat payload for the window stage.
  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    if (accept) begin
      spos_q <= pos_q;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_step_o  = step_q;
  assign s1_pos_o   = spos_q;

endmodule

`default_nettype wire

@@ sv/lwkz_track.sv @@
// Window stage: window start, best length and the output register.
// Takes the popped zero position from the ring read port. Uses lwkz_pkg.
`default_nettype none

module lwkz_track #(
  parameter int unsigned PosW = 17
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s1_valid_i,
  output logic                            s1_ready_o,
  input  wire lwkz_pkg::step_t            s1_step_i,
  input  wire logic [PosW-1:0]            s1_pos_i,
  input  wire logic [PosW-1:0]            ram_rdata_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [lwkz_pkg::BestW-1:0]      best_length_o,
  output logic                            final_result_o,
  output logic                            length_overflow_o
);

  logic [PosW-1:0] ws_q, ws_d, best_q, best_d, best_new, ws_new, pos1, popped, len;
  logic [PosW+lwkz_pkg::BestW-1:0] best_ext;
  logic            out_valid_q, out_valid_d, fire;
  logic [lwkz_pkg::BestW-1:0] obest_q;
  logic            ofinal_q, oovf_q;

  assign s1_ready_o = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_i && s1_ready_o;

  // New window start and running best for this beat.
  assign popped = s1_step_i.fwd ? s1_pos_i : ram_rdata_i;
  assign ws_new = s1_step_i.pop ? popped + PosW'(1) : ws_q;
  assign pos1   = s1_pos_i + PosW'(1);
  assign len    = pos1 - ws_new;

  always_comb begin
    best_new = best_q;
    if (s1_step_i.win && (pos1 > ws_new) && (len > best_q)) begin
      best_new = len;
    end
  end

  assign best_ext = {{lwkz_pkg::BestW{1'b0}}, best_new};

  // Sequence registers clear after the closing beat.
  always_comb begin
    ws_d   = ws_q;
    best_d = best_q;
    if (fire) begin
      if (s1_step_i.last) begin
        ws_d   = '0;
        best_d = '0;
      end else begin
        ws_d   = s1_step_i.win ? ws_new : ws_q;
        best_d = best_new;
      end
    end
  end

  assign out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ws_q        <= ws_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      obest_q  <= best_ext[lwkz_pkg::BestW-1:0];
      ofinal_q <= s1_step_i.last;
      oovf_q   <= s1_step_i.ovf;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign best_length_o     = obest_q;
  assign final_result_o    = ofinal_q;
  assign length_overflow_o = oovf_q;

endmodule

`default_nettype wire

@@ sv/longest_window_k_zeros_core.sv @@
// Longest window with at most k zeros over a bit stream, one result beat per input beat.
// Two register stages: the ring stage (lwkz_ctrl), then the window stage (lwkz_track).
// Throughput: one beat per cycle without output stalls; one ring write and read a cycle.
// Reset clears pointers, counters, window state, the limit and both valid stages.
// The ring memory is not cleared; only entries written in the current sequence are read.
// Depends on lwkz_pkg, lwkz_ring_ram, lwkz_ctrl and lwkz_track.
`default_nettype none

module longest_window_k_zeros_core #(
  parameter int unsigned MAX_LEN = 65536,
  parameter int unsigned MAX_K   = 255
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lwkz_pkg::LimitW-1:0]   cfg_wdata_i,   // max_zeros
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [lwkz_pkg::InDataW-1:0]  s_axis_tdata,  // [0] bit_value, rest zero
  input  wire logic                          s_axis_tlast,  // last_item
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [lwkz_pkg::OutDataW-1:0]      m_axis_tdata,  // [16:0] best_length, rest zero
  output logic                               m_axis_tuser,  // length_overflow
  output logic                               m_axis_tlast   // final_result
);

  localparam int unsigned PosW  = $clog2(MAX_LEN + 1);
  localparam int unsigned Depth = MAX_K + 1;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(MAX_K + 2);

  logic [lwkz_pkg::LimitW-1:0] max_zeros_q;
  logic                        s1_valid, s1_ready;
  lwkz_pkg::step_t             s1_step;
  logic [PosW-1:0]             s1_pos, ram_wdata, ram_rdata;
  logic                        ram_we, ram_re;
  logic [AddrW-1:0]            ram_waddr, ram_raddr;
  logic [lwkz_pkg::BestW-1:0]  best_length;

  // Zero limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_zeros_q <= '0;
    end else if (cfg_we_i) begin
      max_zeros_q <= cfg_wdata_i;
    end
  end

  lwkz_ctrl #(
    .MaxLen (MAX_LEN),
    .MaxK   (MAX_K),
    .PosW   (PosW),
    .AddrW  (AddrW),
    .CntW   (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_zeros_i (max_zeros_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .bit_value_i (s_axis_tdata[0]),
    .last_item_i (s_axis_tlast),
    .s1_ready_i  (s1_ready),
    .s1_valid_o  (s1_valid),
    .s1_step_o   (s1_step),
    .s1_pos_o    (s1_pos),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  lwkz_ring_ram #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (PosW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lwkz_track #(
    .PosW (PosW)
  ) u_track (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s1_valid_i        (s1_valid),
    .s1_ready_o        (s1_ready),
    .s1_step_i         (s1_step),
    .s1_pos_i          (s1_pos),
    .ram_rdata_i       (ram_rdata),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .best_length_o     (best_length),
    .final_result_o    (m_axis_tlast),
    .length_overflow_o (m_axis_tuser)
  );

  assign m_axis_tdata = {{(lwkz_pkg::OutDataW - lwkz_pkg::BestW){1'b0}}, best_length};

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for longest_window_k_zeros_core: a queue-fed stream driver,
// a window-length predictor and a result monitor, under random and directed traffic.
// Depends on lwkz_pkg and the core RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxK      = 255;
  localparam int unsigned RingDepth = MaxK + 1;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned RxHold    = 300;

  typedef struct {
    bit val;
    bit last;
  } bit_beat_t;

  typedef struct {
    logic [lwkz_pkg::BestW-1:0] best;
    logic                       fin;
    logic                       ovf;
  } win_result_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          cfg_we        = 1'b0;
  logic [lwkz_pkg::LimitW-1:0]   cfg_wdata     = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [lwkz_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [lwkz_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;

  // Stimulus and expected results.
  bit_beat_t   bit_stream_q[$];
  win_result_t best_len_q[$];
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_ack     = 0;
  int unsigned hold_left    = 0;
  int unsigned err_cnt      = 0;
  int unsigned quiet_cycles = 0;

  // Predictor state: the window over the current sequence.
  logic [lwkz_pkg::LimitW-1:0] zero_limit;
  int unsigned                 zero_pos[RingDepth];
  logic [7:0]                  ring_rd;
  logic [7:0]                  ring_wr;
  int unsigned                 zeros_held;
  int unsigned                 win_start;
  int unsigned                 seq_pos;
  int unsigned                 best_len;
  bit                          seq_ovf;

  always #4 clk = ~clk;

  longest_window_k_zeros_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [0] bit_value, rest zero
    .s_axis_tlast (s_axis_tlast),   // last_item
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [16:0] best_length, rest zero
    .m_axis_tuser (m_axis_tuser),   // length_overflow
    .m_axis_tlast (m_axis_tlast)    // final_result
  );

  function automatic void clear_window();
    ring_rd    = '0;
    ring_wr    = '0;
    zeros_held = 0;
    win_start  = 0;
    seq_pos    = 0;
    best_len   = 0;
    seq_ovf    = 1'b0;
  endfunction

  // Advances the window by one element and returns the running best length.
  function automatic win_result_t window_step(bit val, bit fin);
    win_result_t r;
    int unsigned lim;
    lim = (zero_limit > MaxK) ? MaxK : zero_limit;
    if (seq_pos >= 65536) begin
      // Elements past the length limit leave the window alone.
      seq_ovf = 1'b1;
    end else begin
      if (!val) begin
        if (zeros_held < RingDepth) begin
          zero_pos[ring_wr] = seq_pos;
          ring_wr++;
          zeros_held++;
        end
        // One zero too many: the window start jumps past the oldest zero.
        if (zeros_held > lim && zeros_held > 0) begin
          win_start = zero_pos[ring_rd] + 1;
          ring_rd++;
          zeros_held--;
        end
      end
      if (seq_pos + 1 > win_start && seq_pos + 1 - win_start > best_len)
        best_len = seq_pos + 1 - win_start;
      seq_pos++;
    end
    r.best = best_len[lwkz_pkg::BestW-1:0];
    r.fin  = fin;
    r.ovf  = seq_ovf;
    if (fin) clear_window();
    return r;
  endfunction

  task automatic flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR at %0t ns: %s", $realtime, msg);
  endtask

  // Driver: offers the next pending element once the previous beat is taken.
  always @(posedge clk) begin
    bit_beat_t b;
    if (!rst_n) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (bit_stream_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        b = bit_stream_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= lwkz_pkg::InDataW'(b.val);
        s_axis_tlast  <= b.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure, plus long holds on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = RxHold;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Monitor: tracks the limit, predicts every input beat and checks every result beat.
  always @(posedge clk) begin
    win_result_t exp_r;
    if (rst_n) begin
      if (cfg_we) zero_limit = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        best_len_q.push_back(window_step(s_axis_tdata[0], s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        if (best_len_q.size() == 0) begin
          flag_error($sformatf("unexpected result beat best=%0d last=%b ovf=%b",
                               m_axis_tdata, m_axis_tlast, m_axis_tuser));
        end else begin
          exp_r = best_len_q.pop_front();
          if (m_axis_tdata !== lwkz_pkg::OutDataW'(exp_r.best) ||
              m_axis_tlast !== exp_r.fin || m_axis_tuser !== exp_r.ovf)
            flag_error($sformatf("best exp %0d got %0d, last exp %b got %b, ovf exp %b got %b",
                                 exp_r.best, m_axis_tdata, exp_r.fin, m_axis_tlast,
                                 exp_r.ovf, m_axis_tuser));
        end
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("Timeout: no beat for %0d cycles", IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_limit(logic [lwkz_pkg::LimitW-1:0] k);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Pattern bit i is element i; the sequence is closed only when asked.
  task automatic push_pattern(logic [63:0] pat, int unsigned len, bit close);
    bit_beat_t b;
    for (int unsigned i = 0; i < len; i++) begin
      b.val  = pat[i];
      b.last = close && (i == len - 1);
      bit_stream_q.push_back(b);
    end
  endtask

  task automatic push_random_seq(int unsigned len, int unsigned zero_pct);
    bit_beat_t b;
    for (int unsigned i = 0; i < len; i++) begin
      b.val  = ($urandom_range(99) >= zero_pct);
      b.last = (i == len - 1);
      bit_stream_q.push_back(b);
    end
  endtask

  // Waits until every element is taken and every result checked, then lets the pipe settle.
  task automatic wait_drained();
    while (bit_stream_q.size() != 0 || s_axis_tvalid || best_len_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_items;
    int unsigned blk_items;
    int unsigned len;
    logic [lwkz_pkg::LimitW-1:0] k;

    zero_limit = '0;
    clear_window();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero limit out of reset, single-element sequences and a six-element one.
    push_pattern(64'b1, 1, 1'b1);
    push_pattern(64'b0, 1, 1'b1);
    push_pattern(64'b111011, 6, 1'b1);
    wait_drained();
    write_limit(8'd2);
    push_pattern(64'b11001000, 8, 1'b1);
    wait_drained();
    write_limit(8'd255);
    push_pattern(64'b100, 3, 1'b1);
    wait_drained();
    // Limit lowered in the middle of a sequence that already holds three zeros.
    write_limit(8'd3);
    push_pattern(64'b1000, 4, 1'b0);
    wait_drained();
    write_limit(8'd1);
    push_pattern(64'b0110, 4, 1'b1);
    wait_drained();

    // Random phases: receiver-heavy idling, sender-heavy idling, then full rate.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 30; rcv_idle_pct = 47; end
        1: begin snd_idle_pct = 47; rcv_idle_pct = 30; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      phase_items = 0;
      while (phase_items < 400) begin
        case ($urandom_range(6))
          0: k = 8'd0;
          1: k = 8'd1;
          2: k = 8'd2;
          3: k = 8'd3;
          4: k = lwkz_pkg::LimitW'($urandom_range(4, 20));
          5: k = lwkz_pkg::LimitW'($urandom_range(0, 255));
          default: k = 8'd255;
        endcase
        write_limit(k);
        // A long receiver hold at the start of each phase fills the pipe.
        if (phase_items == 0) hold_req++;
        blk_items = 0;
        while (blk_items < 120) begin
          len = ($urandom_range(19) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
          push_random_seq(len, $urandom_range(0, 100));
          blk_items += len;
        end
        phase_items += blk_items;
        wait_drained();
      end
    end

    // Ring wrap: more zeros than the ring holds, at the widest limit.
    write_limit(8'd255);
    push_random_seq(400, 90);
    wait_drained();

    repeat (8) @(posedge clk);
    if (err_cnt == 0 && best_len_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
